>>> rtl/core/bmpfb_pkg.sv
// Package for the BMP to framebuffer blitter: widths, header offsets,
// register indexes, phase type and the pixel record between stages.
// No dependencies.
package bmpfb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 800;
    localparam int DEF_SCREEN_HEIGHT = 480;
    localparam int DEF_HEADER_BYTES  = 54;

    localparam int BYTE_W  = 8;
    localparam int DIM_W   = 16;
    localparam int POS_W   = 12;   // screen row/column, 0 to 4095
    localparam int ADDR_W  = 19;
    localparam int WORD_W  = 24;
    localparam int ORGX_W  = 10;
    localparam int ORGY_W  = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int HDR_WIDTH_LO  = 18;
    localparam int HDR_WIDTH_HI  = 19;
    localparam int HDR_HEIGHT_LO = 22;
    localparam int HDR_HEIGHT_HI = 23;

    localparam logic [0:0] REG_ORIGIN_X = 1'b0;
    localparam logic [0:0] REG_ORIGIN_Y = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_PIXELS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_pix;

endpackage

>>> rtl/core/bmpfb_if.sv
// Handshake channels of the blitter: file byte input and framebuffer writes.
// Depends on bmpfb_pkg.
interface bmpfb_in_if;
    logic                        valid;
    logic                        ready;
    logic [bmpfb_pkg::BYTE_W-1:0] file_byte;
    logic                        image_start;

    modport source (output valid, output file_byte, output image_start, input ready);
    modport sink   (input valid, input file_byte, input image_start, output ready);
endinterface

interface bmpfb_out_if;
    logic                         valid;
    logic                         ready;
    logic [bmpfb_pkg::ADDR_W-1:0] fb_address;
    logic [bmpfb_pkg::WORD_W-1:0] pixel_word;
    logic                         image_done;

    modport source (output valid, output fb_address, output pixel_word, output image_done,
                    input ready);
    modport sink   (input valid, input fb_address, input pixel_word, input image_done,
                    output ready);
endinterface

>>> rtl/core/bmpfb_cfg.sv
// APB register block holding the image origin on screen.
// Depends on bmpfb_pkg.
module bmpfb_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmpfb_pkg::PADDR_W-1:0]   paddr,
    input  logic [bmpfb_pkg::PDATA_W-1:0]   pwdata,
    output logic [bmpfb_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,
    output logic [bmpfb_pkg::ORGX_W-1:0]    o_origin_x,
    output logic [bmpfb_pkg::ORGY_W-1:0]    o_origin_y
);
    logic [bmpfb_pkg::ORGX_W-1:0] r_origin_x;
    logic [bmpfb_pkg::ORGY_W-1:0] r_origin_y;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                bmpfb_pkg::REG_ORIGIN_X: r_origin_x <= pwdata[bmpfb_pkg::ORGX_W-1:0];
                bmpfb_pkg::REG_ORIGIN_Y: r_origin_y <= pwdata[bmpfb_pkg::ORGY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bmpfb_pkg::REG_ORIGIN_X: prdata = bmpfb_pkg::PDATA_W'(r_origin_x);
            bmpfb_pkg::REG_ORIGIN_Y: prdata = bmpfb_pkg::PDATA_W'(r_origin_y);
            default:                 prdata = '0;
        endcase
    end

    assign o_origin_x = r_origin_x;
    assign o_origin_y = r_origin_y;
endmodule

>>> rtl/core/bmpfb_parse.sv
// Byte input register and file parser: header capture, pixel assembly,
// row padding, vertical flip and clipping. Emits on-screen pixels.
// Depends on bmpfb_pkg and bmpfb_if.
module bmpfb_parse #(
    parameter int SCREEN_WIDTH  = bmpfb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = bmpfb_pkg::DEF_SCREEN_HEIGHT,
    parameter int HEADER_BYTES  = bmpfb_pkg::DEF_HEADER_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bmpfb_in_if.sink                     i_byte,
    input  logic [bmpfb_pkg::ORGX_W-1:0] i_origin_x,
    input  logic [bmpfb_pkg::ORGY_W-1:0] i_origin_y,
    output logic                         o_pix_valid,
    input  logic                         i_pix_ready,
    output bmpfb_pkg::t_pix              o_pix
);
    localparam int HIDX_W = $clog2(HEADER_BYTES + 1);
    localparam int DW     = bmpfb_pkg::DIM_W;

    // input register
    logic                         r_in_valid;
    logic [bmpfb_pkg::BYTE_W-1:0] r_byte;
    logic                         r_start;

    // parser state
    bmpfb_pkg::t_phase            r_phase, n_phase, e_phase;
    logic [HIDX_W-1:0]            r_hidx, n_hidx;
    logic [DW-1:0]                r_width, n_width;
    logic [DW-1:0]                r_height, n_height;
    logic [1:0]                   r_bip, n_bip;
    logic [bmpfb_pkg::BYTE_W-1:0] r_blue, n_blue;
    logic [bmpfb_pkg::BYTE_W-1:0] r_green, n_green;
    logic [DW-1:0]                r_col, n_col;
    logic [DW-1:0]                r_row, n_row;
    logic [1:0]                   r_pad, n_pad;

    logic                         r_pix_valid;
    bmpfb_pkg::t_pix              r_pix, n_pix;

    logic          emit;
    logic          consume;
    logic          pix_free;
    logic [DW:0]   col_inc;
    logic [DW:0]   row_inc;
    logic [DW:0]   scol;
    logic [DW:0]   srow;
    logic [DW-1:0] flip_row;

    assign scol     = (DW+1)'(i_origin_x) + (DW+1)'(r_col);
    assign flip_row = r_height - DW'(1) - r_row;
    assign srow     = (DW+1)'(i_origin_y) + (DW+1)'(flip_row);
    assign col_inc  = (DW+1)'(r_col) + (DW+1)'(1);
    assign row_inc  = (DW+1)'(r_row) + (DW+1)'(1);

    always_comb begin
        e_phase  = r_start ? bmpfb_pkg::PH_HEADER : r_phase;
        n_phase  = e_phase;
        n_hidx   = r_start ? '0 : r_hidx;
        n_width  = r_start ? '0 : r_width;
        n_height = r_start ? '0 : r_height;
        n_bip    = r_start ? '0 : r_bip;
        n_blue   = r_start ? '0 : r_blue;
        n_green  = r_start ? '0 : r_green;
        n_col    = r_start ? '0 : r_col;
        n_row    = r_start ? '0 : r_row;
        n_pad    = r_start ? '0 : r_pad;
        emit     = 1'b0;
        n_pix.row  = srow[bmpfb_pkg::POS_W-1:0];
        n_pix.col  = scol[bmpfb_pkg::POS_W-1:0];
        n_pix.word = {r_byte, r_green, r_blue};
        n_pix.last = 1'b0;
        case (e_phase)
            bmpfb_pkg::PH_HEADER: begin
                if (n_hidx == HIDX_W'(bmpfb_pkg::HDR_WIDTH_LO))  n_width[7:0]   = r_byte;
                if (n_hidx == HIDX_W'(bmpfb_pkg::HDR_WIDTH_HI))  n_width[15:8]  = r_byte;
                if (n_hidx == HIDX_W'(bmpfb_pkg::HDR_HEIGHT_LO)) n_height[7:0]  = r_byte;
                if (n_hidx == HIDX_W'(bmpfb_pkg::HDR_HEIGHT_HI)) n_height[15:8] = r_byte;
                n_hidx = n_hidx + HIDX_W'(1);
                if (n_hidx >= HIDX_W'(HEADER_BYTES)) begin
                    n_phase = (n_width == '0 || n_height == '0) ? bmpfb_pkg::PH_DONE
                                                                : bmpfb_pkg::PH_PIXELS;
                end
            end
            bmpfb_pkg::PH_PIXELS: begin
                if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                end else begin
                    case (r_bip)
                        2'd0: begin
                            n_blue = r_byte;
                            n_bip  = 2'd1;
                        end
                        2'd1: begin
                            n_green = r_byte;
                            n_bip   = 2'd2;
                        end
                        default: begin
                            n_bip = 2'd0;
                            emit  = scol < (DW+1)'(SCREEN_WIDTH) &&
                                    srow < (DW+1)'(SCREEN_HEIGHT);
                            if (col_inc >= (DW+1)'(r_width)) begin
                                n_col = '0;
                                n_row = row_inc[DW-1:0];
                                n_pad = r_width[1:0];
                                if (row_inc >= (DW+1)'(r_height)) begin
                                    n_pix.last = 1'b1;
                                    n_phase    = bmpfb_pkg::PH_DONE;
                                end
                            end else begin
                                n_col = col_inc[DW-1:0];
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign pix_free     = !r_pix_valid || i_pix_ready;
    assign consume      = r_in_valid && (!emit || pix_free);
    assign i_byte.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte  <= i_byte.file_byte;
            r_start <= i_byte.image_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bmpfb_pkg::PH_IDLE;
            r_hidx   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_bip    <= '0;
            r_blue   <= '0;
            r_green  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pad    <= '0;
        end else if (consume) begin
            r_phase  <= n_phase;
            r_hidx   <= n_hidx;
            r_width  <= n_width;
            r_height <= n_height;
            r_bip    <= n_bip;
            r_blue   <= n_blue;
            r_green  <= n_green;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (pix_free) begin
            r_pix_valid <= consume && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_free && consume && emit) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix_valid = r_pix_valid;
    assign o_pix       = r_pix;
endmodule

>>> rtl/core/bmpfb_addr.sv
// Address stage: row * screen width + column into the output register.
// Depends on bmpfb_pkg and bmpfb_if.
module bmpfb_addr #(
    parameter int SCREEN_WIDTH = bmpfb_pkg::DEF_SCREEN_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pix_valid,
    output logic            o_pix_ready,
    input  bmpfb_pkg::t_pix i_pix,
    bmpfb_out_if.source     o_fb
);
    logic                         r_valid;
    logic [bmpfb_pkg::ADDR_W-1:0] r_addr;
    logic [bmpfb_pkg::WORD_W-1:0] r_word;
    logic                         r_last;
    logic [31:0]                  prod;

    assign prod        = 32'(i_pix.row) * 32'(SCREEN_WIDTH) + 32'(i_pix.col);
    assign o_pix_ready = !r_valid || o_fb.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pix_ready) begin
            r_valid <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pix_ready && i_pix_valid) begin
            r_addr <= prod[bmpfb_pkg::ADDR_W-1:0];
            r_word <= i_pix.word;
            r_last <= i_pix.last;
        end
    end

    assign o_fb.valid      = r_valid;
    assign o_fb.fb_address = r_addr;
    assign o_fb.pixel_word = r_word;
    assign o_fb.image_done = r_last;
endmodule

>>> rtl/core/bmp_to_framebuffer_blit.sv
// Top level of the 24-bit BMP to 24-bit framebuffer blitter.
// Depends on bmpfb_pkg, bmpfb_if, bmpfb_cfg, bmpfb_parse, bmpfb_addr.
//
//   channel   dir  handshake        payload
//   i_byte    in   valid/ready      file_byte[7:0], image_start
//   o_fb      out  valid/ready      fb_address[18:0], pixel_word[23:0], image_done
//   apb       in   psel/penable     paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One file byte per clock, sustained unless an output stall holds a byte that
// completes an on-screen pixel. A byte is registered in the input register and
// then updates the parser, where a pixel it completes enters the pixel register;
// the address register takes it from there and presents the write on o_fb.
// Synchronous active-low reset empties the pipeline and returns the parser to
// idle. Output stalls back up through the pixel and address registers; bytes
// that produce no write keep flowing.
module bmp_to_framebuffer_blit #(
    parameter int SCREEN_WIDTH  = bmpfb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = bmpfb_pkg::DEF_SCREEN_HEIGHT,
    parameter int HEADER_BYTES  = bmpfb_pkg::DEF_HEADER_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bmpfb_in_if.sink                       i_byte,
    bmpfb_out_if.source                    o_fb,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bmpfb_pkg::PADDR_W-1:0]  paddr,
    input  logic [bmpfb_pkg::PDATA_W-1:0]  pwdata,
    output logic [bmpfb_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    logic [bmpfb_pkg::ORGX_W-1:0] w_origin_x;
    logic [bmpfb_pkg::ORGY_W-1:0] w_origin_y;
    logic                         w_pix_valid;
    logic                         w_pix_ready;
    bmpfb_pkg::t_pix              w_pix;

    bmpfb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_origin_x (w_origin_x),
        .o_origin_y (w_origin_y)
    );

    bmpfb_parse #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_origin_x  (w_origin_x),
        .i_origin_y  (w_origin_y),
        .o_pix_valid (w_pix_valid),
        .i_pix_ready (w_pix_ready),
        .o_pix       (w_pix)
    );

    bmpfb_addr #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (w_pix_valid),
        .o_pix_ready (w_pix_ready),
        .i_pix       (w_pix),
        .o_fb        (o_fb)
    );

    // clipping keeps every pixel on screen
    a_pix_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pix_valid |-> (w_pix.row < SCREEN_HEIGHT) && (w_pix.col < SCREEN_WIDTH))
        else $error("pixel outside screen");

    // an empty pixel register never blocks the byte input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pix_valid |-> i_byte.ready)
        else $error("byte input stalled with free pixel stage");

    // nothing follows the last pixel of an image straight away
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pix_valid && w_pix_ready && w_pix.last |=> !w_pix_valid)
        else $error("pixel directly after image end");
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for bmp_to_framebuffer_blit: streams BMP files byte by byte and checks every
// framebuffer write against a listed expected write or a behavioral model kept in step with accepted bytes.
// Depends on bmpfb_pkg, bmpfb_if and the RTL of the blitter.
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SCR_W        = bmpfb_pkg::DEF_SCREEN_WIDTH;
    localparam int SCR_H        = bmpfb_pkg::DEF_SCREEN_HEIGHT;
    localparam int HDR_LEN      = bmpfb_pkg::DEF_HEADER_BYTES;
    localparam int SETTLE       = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int MAX_LINES    = 40;

    localparam int ADDR_W        = bmpfb_pkg::ADDR_W;
    localparam int WORD_W        = bmpfb_pkg::WORD_W;
    localparam int PADDR_W       = bmpfb_pkg::PADDR_W;
    localparam int PDATA_W       = bmpfb_pkg::PDATA_W;
    localparam int ORGX_W        = bmpfb_pkg::ORGX_W;
    localparam int ORGY_W        = bmpfb_pkg::ORGY_W;
    localparam int HDR_WIDTH_LO  = bmpfb_pkg::HDR_WIDTH_LO;
    localparam int HDR_WIDTH_HI  = bmpfb_pkg::HDR_WIDTH_HI;
    localparam int HDR_HEIGHT_LO = bmpfb_pkg::HDR_HEIGHT_LO;
    localparam int HDR_HEIGHT_HI = bmpfb_pkg::HDR_HEIGHT_HI;

    localparam logic [PADDR_W-1:0] ORGX_ADDR = {bmpfb_pkg::REG_ORIGIN_X, 2'b00};
    localparam logic [PADDR_W-1:0] ORGY_ADDR = {bmpfb_pkg::REG_ORIGIN_Y, 2'b00};

    localparam int SRC_IDLE [4] = '{0, 71, 0, 19};
    localparam int SNK_STALL[4] = '{0, 0, 71, 19};

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic              done;
    } t_fb_write;

    // n_typed < 0: writes come from the model; otherwise the listed write (if any) is expected
    typedef struct packed {
        int                ox;
        int                oy;
        logic [31:0]       w;
        logic [31:0]       h;
        int                cut;
        int                lead;
        int                tail;
        bit                rnd_col;
        logic [WORD_W-1:0] col;
        int                n_typed;
        logic [ADDR_W-1:0] t_addr;
        logic [WORD_W-1:0] t_word;
        logic              t_done;
    } t_blit_case;

    localparam int N_DIR = 19;
    localparam t_blit_case DIR_CASES [N_DIR] = '{
        //  ox   oy   width         height        cut lead tail rnd col        typed addr        word        done
        '{  0,   0,   32'd1,        32'd1,        0,  8,   0,   0, 24'hFFFFFF,  1, 19'd0,      24'hFFFFFF, 1'b1},
        '{799, 479,   32'd1,        32'd1,        0,  0,   6,   0, 24'h000000,  1, 19'd383999, 24'h000000, 1'b1},
        '{  0,   0,   32'd0,        32'd5,        0,  0,  10,   1, 24'h000000,  0, 19'd0,      24'h000000, 1'b0},
        '{  0,   0,   32'd3,        32'd0,        0,  0,  10,   1, 24'h000000,  0, 19'd0,      24'h000000, 1'b0},
        '{  0,   0,   32'hA5C30001, 32'h5A3C0001, 0,  0,   0,   0, 24'h123456,  1, 19'd0,      24'h123456, 1'b1},
        '{799,   0,   32'd2,        32'd1,        0,  0,   0,   0, 24'h00FF00,  1, 19'd799,    24'h00FF00, 1'b0},
        '{  0, 479,   32'd1,        32'd2,        0,  0,   0,   0, 24'hFF0000,  1, 19'd383200, 24'hFF0000, 1'b1},
        '{ 10,  20,   32'd5,        32'd3,        0,  0,   0,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{100,  50,   32'd4,        32'd2,        0,  0,   0,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{  0,   0,   32'd6,        32'd2,        0,  0,   0,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{300, 200,   32'd7,        32'd2,        0,  0,   0,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{798, 100,   32'd3,        32'd2,        0,  0,   0,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{799, 478,   32'd2,        32'd3,        0,  0,   0,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{  5,   5,   32'd9,        32'd3,       20,  0,   0,   1, 24'h000000,  0, 19'd0,      24'h000000, 1'b0},
        '{  0,   0,   32'd3,        32'd4,       64,  0,   0,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{  7,   9,   32'd2,        32'hFFFFFFFE, 94,  0,   0,   1, 24'h000000,  0, 19'd0,      24'h000000, 1'b0},
        '{400, 240,   32'd12,       32'd2,        0,  0,   0,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{  0,   0,   32'd8,        32'd3,        0,  0,   3,   1, 24'h000000, -1, 19'd0,      24'h000000, 1'b0},
        '{250,   0,   32'd1,        32'd1,        0,  0,   0,   0, 24'h000000,  1, 19'd250,    24'h000000, 1'b1}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bmpfb_in_if  byte_ch ();
    bmpfb_out_if fb_ch ();

    bmp_to_framebuffer_blit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_fb    (fb_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_fb_write  fb_writes_due[$];
    logic [7:0] file_q[$];
    int         n_err;
    int         cycles;
    int         fed_count;
    int         src_idle;
    int         snk_stall;
    bit         keep_model;
    int         hold_len;
    int         hold_ticket;
    int         hold_seen;
    int         hold_left;

    // model of the blitter
    int                org_x;
    int                org_y;
    int                hdr_pos;
    int                img_w;
    int                img_h;
    int                sub_byte;
    int                col_at;
    int                row_at;
    int                pad_cnt;
    logic [7:0]        b_hold;
    logic [7:0]        g_hold;
    bmpfb_pkg::t_phase model_phase;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_err < MAX_LINES)
            $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        n_err++;
    endtask

    function automatic void clear_image();
        hdr_pos  = 0;
        img_w    = 0;
        img_h    = 0;
        sub_byte = 0;
        b_hold   = '0;
        g_hold   = '0;
        col_at   = 0;
        row_at   = 0;
        pad_cnt  = 0;
    endfunction

    function automatic bit parse_file_byte(input logic [7:0] b, input logic s,
                                           output t_fb_write w);
        int scol;
        int srow;
        bit last;
        w = '0;
        if (s) begin
            clear_image();
            model_phase = bmpfb_pkg::PH_HEADER;
        end
        if (model_phase == bmpfb_pkg::PH_HEADER) begin
            case (hdr_pos)
                HDR_WIDTH_LO:  img_w[7:0]  = b;
                HDR_WIDTH_HI:  img_w[15:8] = b;
                HDR_HEIGHT_LO: img_h[7:0]  = b;
                HDR_HEIGHT_HI: img_h[15:8] = b;
                default: ;
            endcase
            hdr_pos++;
            if (hdr_pos >= HDR_LEN)
                model_phase = (img_w == 0 || img_h == 0) ? bmpfb_pkg::PH_DONE
                                                         : bmpfb_pkg::PH_PIXELS;
            return 1'b0;
        end
        if (model_phase != bmpfb_pkg::PH_PIXELS)
            return 1'b0;
        if (pad_cnt != 0) begin
            pad_cnt--;
            return 1'b0;
        end
        if (sub_byte == 0) begin
            b_hold   = b;
            sub_byte = 1;
            return 1'b0;
        end
        if (sub_byte == 1) begin
            g_hold   = b;
            sub_byte = 2;
            return 1'b0;
        end
        scol     = org_x + col_at;
        srow     = org_y + (img_h - 1 - row_at);
        last     = 1'b0;
        sub_byte = 0;
        col_at++;
        if (col_at >= img_w) begin
            col_at = 0;
            row_at++;
            pad_cnt = img_w & 3;
            if (row_at >= img_h) begin
                last        = 1'b1;
                model_phase = bmpfb_pkg::PH_DONE;
            end
        end
        if (scol >= SCR_W || srow >= SCR_H)
            return 1'b0;
        w.addr = ADDR_W'(srow * SCR_W + scol);
        w.word = {b, g_hold, b_hold};
        w.done = last;
        return 1'b1;
    endfunction

    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_origin(input int ox, input int oy);
        logic [PDATA_W-1:0] rd;
        logic [PDATA_W-1:0] hi;
        hi = $urandom_range(1) ? PDATA_W'($urandom) : '0;
        apb_xfer(1'b1, ORGX_ADDR, (hi & ~32'h3FF) | PDATA_W'(ox), rd);
        apb_xfer(1'b1, ORGY_ADDR, (hi & ~32'h1FF) | PDATA_W'(oy), rd);
        org_x = ox;
        org_y = oy;
        apb_xfer(1'b0, ORGX_ADDR, '0, rd);
        if (rd[ORGX_W-1:0] !== ORGX_W'(ox))
            report_mismatch("origin_x readback", 32'(rd[ORGX_W-1:0]), 32'(ox));
        apb_xfer(1'b0, ORGY_ADDR, '0, rd);
        if (rd[ORGY_W-1:0] !== ORGY_W'(oy))
            report_mismatch("origin_y readback", 32'(rd[ORGY_W-1:0]), 32'(oy));
    endtask

    task automatic drain_writes();
        byte_ch.valid <= 1'b0;
        while (fb_writes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic s);
        t_fb_write w;
        while ($urandom_range(99) < src_idle) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.file_byte   <= b;
        byte_ch.image_start <= s;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        fed_count++;
        if (parse_file_byte(b, s, w) && keep_model)
            fb_writes_due.push_back(w);
    endtask

    task automatic compose_file(input t_blit_case c);
        int                wd;
        int                ht;
        int                lim;
        int                i;
        int                r;
        int                k;
        logic [WORD_W-1:0] px;
        wd  = int'(c.w[15:0]);
        ht  = int'(c.h[15:0]);
        lim = (c.cut > 0) ? c.cut : 32'h7FFFFFFF;
        file_q.delete();
        for (i = 0; i < HDR_LEN; i++) begin
            if (i >= HDR_WIDTH_LO && i < HDR_WIDTH_LO + 4)
                file_q.push_back(c.w[8*(i-HDR_WIDTH_LO) +: 8]);
            else if (i >= HDR_HEIGHT_LO && i < HDR_HEIGHT_LO + 4)
                file_q.push_back(c.h[8*(i-HDR_HEIGHT_LO) +: 8]);
            else
                file_q.push_back(8'($urandom));
        end
        for (r = 0; r < ht && file_q.size() < lim; r++) begin
            for (k = 0; k < wd && file_q.size() < lim; k++) begin
                px = c.rnd_col ? WORD_W'($urandom) : c.col;
                file_q.push_back(px[7:0]);
                file_q.push_back(px[15:8]);
                file_q.push_back(px[23:16]);
            end
            for (k = 0; k < (wd & 3); k++)
                file_q.push_back(8'($urandom));
        end
        while (file_q.size() > lim) void'(file_q.pop_back());
    endtask

    task automatic send_case(input t_blit_case c, input int hold, input int pause_at);
        t_fb_write t;
        if (model_phase != bmpfb_pkg::PH_PIXELS) begin
            drain_writes();
            set_origin(c.ox, c.oy);
        end
        keep_model = (c.n_typed < 0);
        if (c.n_typed > 0) begin
            t.addr = c.t_addr;
            t.word = c.t_word;
            t.done = c.t_done;
            fb_writes_due.push_back(t);
        end
        if (hold > 0) begin
            hold_len = hold;
            hold_ticket <= hold_ticket + 1;
        end
        repeat (c.lead) feed_byte(8'($urandom), 1'b0);
        compose_file(c);
        foreach (file_q[i]) begin
            if (i == pause_at)
                drain_writes();
            feed_byte(file_q[i], i == 0);
        end
        repeat (c.tail) feed_byte(8'($urandom), 1'b0);
    endtask

    function automatic int pick_origin(input int top);
        case ($urandom_range(7))
            0:       return 0;
            1:       return top;
            2:       return top - int'($urandom_range(9));
            default: return int'($urandom_range(top));
        endcase
    endfunction

    task automatic random_case(output t_blit_case c);
        int k;
        int len;
        c         = '0;
        c.n_typed = -1;
        c.rnd_col = ($urandom_range(9) != 0);
        c.col     = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        c.ox      = pick_origin(SCR_W - 1);
        c.oy      = pick_origin(SCR_H - 1);
        k         = $urandom_range(99);
        if (k < 75) begin
            c.w = ($urandom_range(9) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
            c.h = $urandom_range(5, 1);
            if ($urandom_range(3) == 0)
                c.w[31:16] = 16'($urandom);
            if ($urandom_range(3) == 0)
                c.h[31:16] = 16'($urandom);
            len    = HDR_LEN + int'(c.h[15:0]) * (3 * int'(c.w[15:0]) + int'(c.w[1:0]));
            c.cut  = ($urandom_range(9) == 0) ? int'($urandom_range(len - 1, 1)) : 0;
            c.lead = $urandom_range(2);
            c.tail = $urandom_range(3);
        end else if (k < 85) begin
            c.w = $urandom_range(8);
            c.h = $urandom_range(8);
            if ($urandom_range(1))
                c.w[15:0] = '0;
            else
                c.h[15:0] = '0;
            c.w[31:16] = 16'($urandom);
            c.tail     = $urandom_range(8);
        end else begin
            c.w    = $urandom;
            c.h    = $urandom;
            c.cut  = $urandom_range(150, 1);
            c.lead = $urandom_range(4);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen   <= hold_ticket;
            hold_left   <= hold_len;
            fb_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            fb_ch.ready <= 1'b0;
        end else begin
            fb_ch.ready <= ($urandom_range(99) >= snk_stall);
        end
    end

    always @(posedge i_clk) begin : fb_monitor
        t_fb_write got;
        t_fb_write want;
        if (i_rst_n && fb_ch.valid && fb_ch.ready) begin
            got.addr = fb_ch.fb_address;
            got.word = fb_ch.pixel_word;
            got.done = fb_ch.image_done;
            if (fb_writes_due.size() == 0) begin
                report_mismatch("write with nothing due, fb_address", 32'(got.addr), 32'h0);
            end else begin
                want = fb_writes_due.pop_front();
                if (got.addr !== want.addr)
                    report_mismatch("fb_address", 32'(got.addr), 32'(want.addr));
                if (got.word !== want.word)
                    report_mismatch("pixel_word", 32'(got.word), 32'(want.word));
                if (got.done !== want.done)
                    report_mismatch("image_done", 32'(got.done), 32'(want.done));
            end
        end
    end

    initial begin
        t_blit_case c;
        int         base;
        int         p;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.file_byte   = '0;
        byte_ch.image_start = 1'b0;
        fb_ch.ready         = 1'b0;
        n_err               = 0;
        cycles              = 0;
        fed_count           = 0;
        src_idle            = 0;
        snk_stall           = 0;
        keep_model          = 1'b1;
        hold_len            = 0;
        hold_ticket         = 0;
        hold_seen           = 0;
        hold_left           = 0;
        org_x               = 0;
        org_y               = 0;
        clear_image();
        model_phase         = bmpfb_pkg::PH_IDLE;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send_case(DIR_CASES[i], 0, -1);

        for (p = 0; p < 4; p++) begin
            src_idle  = SRC_IDLE[p];
            snk_stall = SNK_STALL[p];
            base      = fed_count;
            if (p == 0 || p == 1) begin
                c         = '0;
                c.n_typed = -1;
                c.rnd_col = 1'b1;
                c.ox      = 100;
                c.oy      = 100;
                c.w       = (p == 0) ? 32'd8 : 32'd12;
                c.h       = 32'd3;
                // long output hold-off first, then a mid-image pause until all writes land
                send_case(c, (p == 0) ? 200 : 0, (p == 1) ? 110 : -1);
            end
            while (fed_count - base < PHASE_ITEMS) begin
                random_case(c);
                send_case(c, 0, -1);
            end
        end

        drain_writes();
        if (n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
